@@ sv/lkv_pkg.sv @@
// Shared constants, types and a helper function of the LRU key-value cache.
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int REC_W   = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]  CAP_RESET    = CAP_W'(16);

    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [REC_W-1:0]   rec;
    } t_slot_view;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   hit_idx;
        logic [VALUE_W-1:0] hit_value;
        logic [REC_W-1:0]   hit_rec;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic               old_found;
        logic [IDX_W-1:0]   old_idx;
        logic [REC_W-1:0]   old_rec;
    } t_scan_res;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic               new_entry;
        logic               write_key;
        logic               write_value;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   age_ref;
    } t_apply;

    function automatic logic [CMP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (c == '0) begin
            c = CMP_W'(1);
        end
        if (c > CMP_W'(ENTRIES)) begin
            c = CMP_W'(ENTRIES);
        end
        return c;
    endfunction

endpackage

@@ sv/lkv_store.sv @@
// Entry store: valid bits, keys, values, recency ranks and occupancy count.
module lkv_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lkv_pkg::IDX_W-1:0] i_rd_idx,
    output lkv_pkg::t_slot_view       o_view,
    input  lkv_pkg::t_apply           i_cmd,
    output logic [lkv_pkg::CNT_W-1:0] o_occ
);
    import lkv_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]   r_key   [ENTRIES];
    logic [VALUE_W-1:0] r_value [ENTRIES];
    logic [REC_W-1:0]   r_rec   [ENTRIES];
    logic [CNT_W-1:0]   r_occ;

    always_comb begin
        o_view.valid = r_valid[i_rd_idx];
        o_view.key   = r_key[i_rd_idx];
        o_view.value = r_value[i_rd_idx];
        o_view.rec   = r_rec[i_rd_idx];
    end

    assign o_occ = r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rec[i] <= '0;
            end
        end else if (i_cmd.en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == i_cmd.idx) begin
                    r_rec[i] <= '0;
                end else if (r_valid[i] && (CNT_W'(r_rec[i]) < i_cmd.age_ref)) begin
                    r_rec[i] <= r_rec[i] + REC_W'(1);
                end
            end
            if (i_cmd.new_entry) begin
                r_valid[i_cmd.idx] <= 1'b1;
                r_occ              <= r_occ + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en && i_cmd.write_key) begin
            r_key[i_cmd.idx] <= i_cmd.key;
        end
        if (i_cmd.en && i_cmd.write_value) begin
            r_value[i_cmd.idx] <= i_cmd.value;
        end
    end

endmodule

@@ sv/lkv_scan.sv @@
// Slot scanner: one compare step per cycle while i_step is high, over all slots to find hit, free and oldest.
module lkv_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_step,
    input  logic [lkv_pkg::KEY_W-1:0] i_key,
    input  lkv_pkg::t_slot_view       i_view,
    output logic [lkv_pkg::IDX_W-1:0] o_idx,
    output logic                      o_last,
    output lkv_pkg::t_scan_res        o_res
);
    import lkv_pkg::*;

    logic [IDX_W-1:0] r_idx;
    t_scan_res        r_res;
    t_scan_res        n_res;
    logic             key_match;
    logic             older;

    assign o_idx     = r_idx;
    assign o_last    = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_res     = r_res;
    assign key_match = i_view.valid && (i_view.key == i_key);
    assign older     = i_view.valid && (!r_res.old_found || (i_view.rec > r_res.old_rec));

    always_comb begin
        n_res = r_res;
        if (i_start) begin
            n_res.found      = 1'b0;
            n_res.free_found = 1'b0;
            n_res.old_found  = 1'b0;
        end else if (i_step) begin
            if (!r_res.found && key_match) begin
                n_res.found     = 1'b1;
                n_res.hit_idx   = r_idx;
                n_res.hit_value = i_view.value;
                n_res.hit_rec   = i_view.rec;
            end
            if (!r_res.free_found && !i_view.valid) begin
                n_res.free_found = 1'b1;
                n_res.free_idx   = r_idx;
            end
            if (older) begin
                n_res.old_found = 1'b1;
                n_res.old_idx   = r_idx;
                n_res.old_rec   = i_view.rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_res <= '0;
        end else begin
            r_res <= n_res;
            if (i_start) begin
                r_idx <= '0;
            end else if (i_step && !o_last) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

endmodule

@@ sv/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: request sequencer, result register and APB port.
// A request is compared against every slot in ST_SCAN, then applied in ST_APPLY, which for a get
// waits for a free output register; a new request is taken only in ST_IDLE.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous and active low; it clears all valid bits, ranks and the occupancy.
// Capacity resets to 16; no clearing pass is needed after reset.
module lru_key_value_cache (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_kind,
    input  logic [lkv_pkg::KEY_W-1:0]   i_key,
    input  logic signed [lkv_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_hit,
    output logic signed [lkv_pkg::VALUE_W-1:0] o_read_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
    output logic [lkv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import lkv_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CAP_W-1:0]   r_cap;
    t_kind              r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [VALUE_W-1:0] r_out_value;

    logic               accept;
    logic               scan_step;
    logic               scan_last;
    logic               proceed;
    logic               room;
    logic               load_out;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   occ;
    t_slot_view         view;
    t_scan_res          res;
    t_apply             cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? DATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[ADDR_W-1:2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign accept = i_valid && o_ready;
    assign room   = CMP_W'(occ) < eff_cap(r_cap);

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        scan_step = 1'b0;
        proceed   = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_step = 1'b1;
                if (scan_last) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (r_kind == KIND_PUT) begin
                    proceed = 1'b1;
                    n_state = ST_IDLE;
                end else if (!r_out_valid || i_ready) begin
                    proceed  = 1'b1;
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.en          = proceed && (res.found || (r_kind == KIND_PUT));
        cmd.new_entry   = !res.found && room;
        cmd.write_key   = (r_kind == KIND_PUT) && !res.found;
        cmd.write_value = (r_kind == KIND_PUT);
        cmd.key         = r_key;
        cmd.value       = r_value;
        if (res.found) begin
            cmd.idx     = res.hit_idx;
            cmd.age_ref = CNT_W'(res.hit_rec);
        end else if (room) begin
            cmd.idx     = res.free_idx;
            cmd.age_ref = occ;
        end else begin
            cmd.idx     = res.old_idx;
            cmd.age_ref = CNT_W'(res.old_rec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= t_kind'(i_kind);
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (load_out) begin
            r_out_hit   <= res.found;
            r_out_value <= res.found ? res.hit_value : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = $signed(r_out_value);

    lkv_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_step  (scan_step),
        .i_key   (r_key),
        .i_view  (view),
        .o_idx   (rd_idx),
        .o_last  (scan_last),
        .o_res   (res)
    );

    lkv_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .o_view   (view),
        .i_cmd    (cmd),
        .o_occ    (occ)
    );

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(occ) <= CNT_W'(ENTRIES))
        else $error("Occupancy exceeds the number of entries.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("Request taken while a previous request is in progress.");

    a_put_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY && r_kind == KIND_PUT) |=> !$rose(o_valid))
        else $error("A put request produced a result.");

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.en && !res.found && !room) |-> res.old_found)
        else $error("Eviction without a valid least recent entry.");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the LRU key-value cache: random traffic, live predictor, APB setup.
module testbench;
    import lkv_pkg::*;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } cache_req_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
    } lookup_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PERIODIC,
        READY_RARELY
    } ready_style_t;

    localparam logic [ADDR_W-1:0] CAP_ADDR      = {REG_CAPACITY, 2'b00};
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);
    localparam int DRAIN_CYCLES  = 2 * ENTRIES + 8;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 114;
    localparam int POOL_MAX      = 40;
    localparam int REPORT_LIMIT  = 10;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  i_valid  = 1'b0;
    logic                  o_ready;
    logic                  i_kind   = 1'b0;
    logic [KEY_W-1:0]      i_key    = '0;
    logic [VALUE_W-1:0]    i_value  = '0;
    logic                  o_valid;
    logic                  i_ready  = 1'b0;
    logic                  o_hit;
    logic [VALUE_W-1:0]    o_read_value;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [DATA_W-1:0]     pwdata   = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    lru_key_value_cache u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cache_req_t     pending_q[$];
    lookup_result_t lookup_q[$];

    logic               line_valid [ENTRIES];
    logic [KEY_W-1:0]   line_key   [ENTRIES];
    logic [VALUE_W-1:0] line_value [ENTRIES];
    logic [REC_W-1:0]   line_age   [ENTRIES];
    int                 line_count;
    logic [CAP_W-1:0]   capacity_reg = CAP_RESET;

    int fail_count     = 0;
    int result_count   = 0;
    int get_count      = 0;
    int hit_count      = 0;
    int put_count      = 0;
    int eviction_count = 0;
    int setting_count  = 0;

    logic         req_taken = 1'b0;
    int           burst_left = 1;
    int           gap_left   = 0;
    ready_style_t ready_style = READY_ALWAYS;
    logic         hold_kick = 1'b0;
    logic         hold_seen = 1'b0;
    int           hold_left = 0;
    int           rx_cycle  = 0;

    function automatic int usable_lines(input logic [CAP_W-1:0] cap);
        int c;
        c = int'(cap);
        if (c < 1) begin
            c = 1;
        end
        if (c > ENTRIES) begin
            c = ENTRIES;
        end
        return c;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic make_most_recent(input int slot);
        logic [REC_W-1:0] age;
        age = line_age[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != slot && line_valid[i] && line_age[i] < age) begin
                line_age[i] = line_age[i] + 1'b1;
            end
        end
        line_age[slot] = '0;
    endtask

    task automatic cache_access(input t_kind kind, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        int             slot;
        logic [REC_W-1:0] oldest;
        logic           found;
        lookup_result_t res;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && line_valid[i] && line_key[i] == key) begin
                slot = i;
            end
        end
        if (kind == KIND_GET) begin
            get_count++;
            if (slot >= 0) begin
                hit_count++;
                make_most_recent(slot);
                res.hit = 1'b1;
                res.read_value = line_value[slot];
            end else begin
                res.hit = 1'b0;
                res.read_value = '0;
            end
            lookup_q.push_back(res);
        end else begin
            put_count++;
            if (slot >= 0) begin
                line_value[slot] = value;
            end else if (line_count < usable_lines(capacity_reg)) begin
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (!line_valid[i]) begin
                        slot = i;
                    end
                end
                line_valid[slot] = 1'b1;
                line_age[slot] = REC_W'(line_count);
                line_count++;
            end else begin
                eviction_count++;
                found = 1'b0;
                oldest = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (line_valid[i] && (!found || line_age[i] > oldest)) begin
                        oldest = line_age[i];
                        slot = i;
                        found = 1'b1;
                    end
                end
            end
            line_key[slot] = key;
            line_value[slot] = value;
            make_most_recent(slot);
        end
    endtask

    always @(negedge i_clk) begin : request_driver
        cache_req_t item;
        if (!i_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                item = pending_q.pop_front();
                i_valid <= 1'b1;
                i_kind  <= item.kind;
                i_key   <= item.key;
                i_value <= item.value;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_receiver
        if (hold_seen != hold_kick) begin
            hold_seen = hold_kick;
            hold_left = LONG_HOLD;
        end
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (ready_style)
                READY_ALWAYS:   i_ready <= 1'b1;
                READY_MOSTLY:   i_ready <= ($urandom_range(0, 3) != 0);
                READY_PERIODIC: i_ready <= (rx_cycle % 5 == 0);
                default:        i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : result_monitor
        lookup_result_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                result_count++;
                if (lookup_q.size() == 0) begin
                    report_failure($sformatf("Unexpected result hit=%0b read_value=%0d",
                                             o_hit, $signed(o_read_value)));
                end else begin
                    want = lookup_q.pop_front();
                    if (o_hit !== want.hit) begin
                        report_failure($sformatf("Result %0d hit: expected %0b, got %0b",
                                                 result_count, want.hit, o_hit));
                    end
                    if (o_read_value !== want.read_value) begin
                        report_failure($sformatf(
                            "Result %0d read_value: expected %0d, got %0d", result_count,
                            $signed(want.read_value), $signed(o_read_value)));
                    end
                end
            end
            if (i_valid && o_ready) begin
                cache_access(t_kind'(i_kind), i_key, i_value);
            end
        end
        req_taken <= i_rst_n && i_valid && o_ready;
    end

    task automatic queue_request(input t_kind kind, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] value);
        cache_req_t r;
        r.kind = kind;
        r.key = key;
        r.value = value;
        pending_q.push_back(r);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || i_valid || lookup_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_capacity_readback();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = CAP_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== DATA_W'(capacity_reg)) begin
            report_failure($sformatf("Capacity readback: expected %0d, got %0d",
                                     capacity_reg, prdata));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap, input logic [DATA_W-1:0] upper);
        logic [DATA_W-1:0] data;
        data = (upper & ~DATA_W'({CAP_W{1'b1}})) | DATA_W'(cap);
        apb_write(CAP_ADDR, data);
        capacity_reg = cap;
        setting_count++;
        check_capacity_readback();
    endtask

    task automatic random_phase(input int count);
        logic [KEY_W-1:0]   key_pool [POOL_MAX];
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
        int                 pool_n;
        int                 lines;
        lines = usable_lines(capacity_reg);
        pool_n = $urandom_range(lines, 2 * lines + 2);
        for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(0, 9))
                0:       key_pool[i] = '0;
                1:       key_pool[i] = '1;
                default: key_pool[i] = KEY_W'($urandom());
            endcase
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 6) != 0) begin
                key = key_pool[$urandom_range(0, pool_n - 1)];
            end else begin
                key = KEY_W'($urandom());
            end
            case ($urandom_range(0, 9))
                0:       value = {1'b1, {(VALUE_W - 1){1'b0}}};
                1:       value = {1'b0, {(VALUE_W - 1){1'b1}}};
                2:       value = '1;
                3:       value = '0;
                default: value = $urandom();
            endcase
            queue_request($urandom_range(0, 1) ? KIND_PUT : KIND_GET, key, value);
        end
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0] cap_plan [11];
        cap_plan = '{5'd4, 5'd1, 5'd31, 5'd2, 5'd8, 5'd17, 5'd0, 5'd16, 5'd12, 5'd3, 5'd5};
        for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_key[i] = '0;
            line_value[i] = '0;
            line_age[i] = '0;
        end
        line_count = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        check_capacity_readback();

        queue_request(KIND_GET, 16'h0000, 32'h1234_5678);
        queue_request(KIND_PUT, 16'h0000, 32'h8000_0000);
        queue_request(KIND_PUT, 16'hFFFF, 32'h7FFF_FFFF);
        queue_request(KIND_PUT, 16'h1234, 32'hFFFF_FFFF);
        queue_request(KIND_GET, 16'hFFFF, 32'h0000_0000);
        queue_request(KIND_GET, 16'h0000, 32'hFFFF_FFFF);
        queue_request(KIND_PUT, 16'h0000, 32'h0000_0000);
        queue_request(KIND_GET, 16'h0000, 32'h0000_0000);
        queue_request(KIND_GET, 16'h5555, 32'h5555_5555);
        queue_request(KIND_GET, 16'hAAAA, 32'h0000_0000);
        drain();

        // Capacity drops below the number of held entries; inserts now replace the oldest.
        set_capacity(5'd2, $urandom());
        queue_request(KIND_PUT, 16'hAAAA, 32'hAAAA_AAAA);
        queue_request(KIND_PUT, 16'h5555, 32'h5555_5555);
        queue_request(KIND_GET, 16'hAAAA, 32'h0000_0000);
        queue_request(KIND_PUT, 16'h0F0F, 32'h0F0F_0F0F);
        queue_request(KIND_GET, 16'h5555, 32'h0000_0000);
        queue_request(KIND_GET, 16'h0F0F, 32'h0000_0000);
        queue_request(KIND_GET, 16'hAAAA, 32'h0000_0000);
        drain();

        // A capacity of zero behaves as one.
        set_capacity(5'd0, $urandom());
        queue_request(KIND_PUT, 16'h00FF, 32'h0000_0001);
        queue_request(KIND_GET, 16'h00FF, 32'h0000_0000);
        queue_request(KIND_PUT, 16'hFF00, 32'h0000_0002);
        queue_request(KIND_GET, 16'h00FF, 32'h0000_0000);
        queue_request(KIND_GET, 16'hFF00, 32'h0000_0000);
        drain();

        apb_write(UNMAPPED_ADDR, 32'h0000_0007);
        check_capacity_readback();

        for (int p = 0; p < 11; p++) begin
            set_capacity(cap_plan[p], $urandom());
            @(posedge i_clk);
            ready_style = ready_style_t'(p % 4);
            if (cap_plan[p] == 5'd8) begin
                ready_style = READY_MOSTLY;
                hold_kick = ~hold_kick;
            end
            random_phase(PHASE_ITEMS);
            drain();
        end

        $display("Covered %0d gets (%0d hits), %0d puts and %0d evictions",
                 get_count, hit_count, put_count, eviction_count);
        $display("across %0d capacity settings with sender gaps and receiver stalls.",
                 setting_count);
        if (lookup_q.size() != 0) begin
            report_failure($sformatf("%0d expected results never arrived", lookup_q.size()));
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failures", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("Timeout with %0d results outstanding", lookup_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
